// ===== rtl/srs_pkg.sv =====
`default_nettype none

package srs_pkg;

    localparam int JOB_BYTES  = 8;
    localparam int CNT_W      = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_BYTES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACEMENT_LEN   = 2'd3;

    // one accepted request worth of results: count bytes, oldest in low bits
    typedef struct packed {
        logic [JOB_BYTES*8-1:0] data;
        logic [CNT_W-1:0]       count;
        logic                   last;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

`default_nettype wire

// ===== rtl/srs_in_if.sv =====
`default_nettype none

interface srs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

`default_nettype wire

// ===== rtl/srs_out_if.sv =====
`default_nettype none

interface srs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_has_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_has_byte, output out_last,
                    input ready);
    modport sink   (input valid, input out_byte, input out_has_byte, input out_last,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/srs_front.sv =====
`default_nettype none

module srs_front #(
    parameter int MAX_PATTERN = 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [srs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [srs_pkg::CFG_DATA_W-1:0]     cfg_data,
    srs_in_if.sink                                  stream,
    input  wire srs_pkg::queue_status_t             q_status,
    output logic                                    push,
    output srs_pkg::job_t                           job
);

    localparam int FW = $clog2(MAX_PATTERN + 1);
    localparam int CW = srs_pkg::CNT_W;

    logic [63:0]            pattern_reg;
    logic [3:0]             plen_reg;
    logic [63:0]            repl_reg;
    logic [3:0]             rlen_reg;

    logic [MAX_PATTERN*8-1:0] win_reg;
    logic [MAX_PATTERN*8-1:0] win_next;
    logic [FW-1:0]            fill_reg;
    logic [FW-1:0]            fill_next;

    logic [FW-1:0]            fill_c;
    logic [CW-1:0]            f1;
    logic [CW-1:0]            plen;
    logic [CW-1:0]            rlen;
    logic [MAX_PATTERN*8-1:0] w1;
    logic                     match;
    logic                     over;
    logic                     full_eq;
    logic                     use_repl;
    logic [CW-1:0]            k;
    logic                     accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg <= '0;
            plen_reg    <= 4'd1;
            repl_reg    <= '0;
            rlen_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                srs_pkg::CFG_PATTERN_BYTES:     pattern_reg <= cfg_data;
                srs_pkg::CFG_PATTERN_LENGTH:    plen_reg    <= cfg_data[3:0];
                srs_pkg::CFG_REPLACEMENT_BYTES: repl_reg    <= cfg_data;
                srs_pkg::CFG_REPLACEMENT_LEN:   rlen_reg    <= cfg_data[3:0];
                default:                        ;
            endcase
        end
    end

    assign stream.ready = !q_status.full;
    assign accept       = stream.valid && stream.ready;

    always_comb
    begin
        fill_c = (fill_reg >= FW'(MAX_PATTERN)) ? FW'(MAX_PATTERN - 1) : fill_reg;
        f1     = CW'(fill_c) + 4'd1;

        if (plen_reg == 4'd0)
            plen = 4'd1;
        else if (plen_reg > CW'(MAX_PATTERN))
            plen = CW'(MAX_PATTERN);
        else
            plen = plen_reg;

        rlen = (rlen_reg > CW'(srs_pkg::JOB_BYTES)) ? CW'(srs_pkg::JOB_BYTES) : rlen_reg;

        for (int i = 0; i < MAX_PATTERN; i++)
            w1[i*8 +: 8] = (FW'(i) == fill_c) ? stream.in_byte : win_reg[i*8 +: 8];

        match = 1'b1;
        for (int i = 0; i < MAX_PATTERN; i++)
            if (CW'(i) < plen && w1[i*8 +: 8] != pattern_reg[i*8 +: 8])
                match = 1'b0;

        over     = f1 > plen;
        full_eq  = f1 == plen;
        use_repl = full_eq && match;

        if (use_repl)
            k = rlen;
        else if (stream.in_last)
            k = f1;
        else if (over)
            k = f1 - plen + 4'd1;
        else if (full_eq)
            k = 4'd1;
        else
            k = '0;

        if (use_repl)
        begin
            win_next  = '0;
            fill_next = '0;
        end
        else
        begin
            win_next  = w1 >> {k, 3'b000};
            fill_next = FW'(f1 - k);
        end

        job.data  = use_repl ? repl_reg : (srs_pkg::JOB_BYTES*8)'(w1);
        job.count = k;
        job.last  = stream.in_last;
        push      = accept && (k != '0 || stream.in_last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= '0;
        else if (accept)
            fill_reg <= fill_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            win_reg <= win_next;
    end

endmodule

`default_nettype wire

// ===== rtl/srs_fifo.sv =====
`default_nettype none

module srs_fifo #(
    parameter int DEPTH = 4
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire srs_pkg::job_t           wr_job,
    input  wire logic                    pop,
    output srs_pkg::job_t                rd_job,
    output srs_pkg::queue_status_t       status
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    srs_pkg::job_t  mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  rd_ptr_reg;
    logic [NW-1:0]  count_reg;
    logic [NW-1:0]  count_next;

    assign status.full  = count_reg == NW'(DEPTH);
    assign status.empty = count_reg == '0;
    assign rd_job       = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_job;
    end

endmodule

`default_nettype wire

// ===== rtl/srs_back.sv =====
`default_nettype none

module srs_back (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire srs_pkg::job_t           rd_job,
    input  wire srs_pkg::queue_status_t  q_status,
    output logic                         pop,
    srs_out_if.source                    result
);

    localparam int CW = srs_pkg::CNT_W;
    localparam int DW = srs_pkg::JOB_BYTES * 8;

    logic           cur_valid_reg;
    logic [DW-1:0]  cur_data_reg;
    logic [CW-1:0]  cur_rem_reg;
    logic           cur_last_reg;

    logic           out_valid_reg;
    logic [7:0]     out_byte_reg;
    logic           out_has_reg;
    logic           out_last_reg;

    logic           load_ok;
    logic           emit;
    logic           finish;

    assign load_ok = !out_valid_reg || result.ready;
    assign emit    = cur_valid_reg && load_ok;
    assign finish  = emit && cur_rem_reg <= 4'd1;
    assign pop     = !q_status.empty && (!cur_valid_reg || finish);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
                cur_valid_reg <= 1'b1;
            else if (finish)
                cur_valid_reg <= 1'b0;
            if (load_ok)
                out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_data_reg <= rd_job.data;
            cur_rem_reg  <= rd_job.count;
            cur_last_reg <= rd_job.last;
        end
        else if (emit)
        begin
            cur_data_reg <= cur_data_reg >> 8;
            cur_rem_reg  <= cur_rem_reg - 1'b1;
        end

        if (emit)
        begin
            out_has_reg  <= cur_rem_reg != '0;
            out_byte_reg <= (cur_rem_reg != '0) ? cur_data_reg[7:0] : 8'd0;
            out_last_reg <= cur_last_reg && cur_rem_reg <= 4'd1;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.out_byte     = out_byte_reg;
    assign result.out_has_byte = out_has_reg;
    assign result.out_last     = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/substring_replace_stream_core.sv =====
`default_nettype none

// Streaming find-and-replace on a byte string, one byte per request, the final byte
// flagged. A window of up to pattern_length bytes is held; a full window equal to
// the pattern is replaced (leftmost, non-overlapping), otherwise the oldest byte
// passes through, and the tail is flushed on the final byte. A string end that
// yields no byte gives one result with out_has_byte low. The front takes one
// request per cycle while the job queue (QUEUE_DEPTH entries) has room; the back
// sends one result per cycle while the output is accepted. A request yields one
// result for plain pass-through and up to eight for a replacement or a flush,
// and the queue absorbs the difference. The user must write configuration only
// while the block is idle; the block itself does not enforce this.
module substring_replace_stream_core #(
    parameter int MAX_PATTERN = 8,
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [srs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [srs_pkg::CFG_DATA_W-1:0]     cfg_data,
    srs_in_if.sink                                  stream,
    srs_out_if.source                               result
);

    srs_pkg::job_t          wr_job;
    srs_pkg::job_t          rd_job;
    srs_pkg::queue_status_t q_status;
    logic                   push;
    logic                   pop;

    srs_front #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stream    (stream),
        .q_status  (q_status),
        .push      (push),
        .job       (wr_job)
    );

    srs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_job (wr_job),
        .pop    (pop),
        .rd_job (rd_job),
        .status (q_status)
    );

    srs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_job   (rd_job),
        .q_status (q_status),
        .pop      (pop),
        .result   (result)
    );

endmodule

`default_nettype wire
